// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the cache block; only sacl_ctrl includes them.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sacl_pkg.sv =====
// Shared types and constants of the set-associative LRU cache.
// Depends on nothing; used by the controller, datapath and top level.
package sacl_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W = 32;
  localparam int SET_OUT_W = 6;
  localparam int WAY_OUT_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WAYS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SETS = 1'd1;

  typedef struct packed {
    logic start_mod;
    logic step_mod;
    logic read_set;
    logic decide;
    logic write_back;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic mod_done;
    logic clear_done;
  } stat_t;

endpackage

// ===== hw/rtl/sacl_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; used for the per-set tag, rank and valid memories.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/sacl_ctrl.sv =====
// Controller state machine of the LRU cache: sequences the clearing pass, the
// set modulo, memory read, decision and write back. Depends on sacl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sacl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sacl_pkg::ctrl_t ctrl,
  input  sacl_pkg::stat_t stat
);
  import sacl_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_READ, S_DECIDE, S_WRITE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    ctrl = '0;
    ctrl.start_mod = in_valid && in_ready;
    ctrl.step_mod = (state == S_MOD);
    ctrl.read_set = (state == S_MOD) && stat.mod_done;
    ctrl.decide = (state == S_DECIDE);
    ctrl.write_back = (state == S_WRITE) || (state == S_CLEAR);
    ctrl.load_out = (state == S_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (stat.clear_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (stat.mod_done) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_DECIDE;
        S_DECIDE: state <= S_WRITE;
        S_WRITE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready, "accept while busy")
  `ASSERT_NEXT(a_write_valid, clk, rst, state == S_WRITE, out_valid, "result not presented")
  `ASSERT_IMPLY(a_one_cmd, clk, rst, 1'b1, $onehot0({ctrl.decide, ctrl.write_back, ctrl.step_mod}),
    "overlapping commands")

endmodule

// ===== hw/rtl/sacl_dp.sv =====
// Datapath of the LRU cache: serial modulo, set memories, valid bits,
// hit and victim search, rank update and counters. Depends on sacl_pkg, sacl_ram.
module sacl_dp #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [sacl_pkg::ADDR_W-1:0]     address,
  input  sacl_pkg::ctrl_t                ctrl,
  output sacl_pkg::stat_t                stat,
  output logic                           hit,
  output logic [sacl_pkg::SET_OUT_W-1:0]  set_index,
  output logic [sacl_pkg::WAY_OUT_W-1:0]  way_index,
  output logic                           evicted,
  output logic [sacl_pkg::CNT_W-1:0]      hit_total,
  output logic [sacl_pkg::CNT_W-1:0]      miss_total
);
  import sacl_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int SCNT_W = $clog2(MAX_SETS + 1);
  localparam int STEP_W = $clog2(ADDR_W + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic [3:0] active_ways;
  logic [6:0] num_sets;
  logic [WCNT_W-1:0] ways_eff;
  logic [SCNT_W-1:0] sets_eff;

  always_comb begin
    if (active_ways == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(active_ways) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(active_ways);
    end
    if (num_sets == 7'd0) begin
      sets_eff = SCNT_W'(1);
    end else if (32'(num_sets) > MAX_SETS) begin
      sets_eff = SCNT_W'(MAX_SETS);
    end else begin
      sets_eff = SCNT_W'(num_sets);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways <= 4'd8;
      num_sets <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACTIVE_WAYS: active_ways <= cfg_data[3:0];
        REG_NUM_SETS: num_sets <= cfg_data;
        default: ;
      endcase
    end
  end

  // Restoring modulo, one address bit per cycle.
  logic [ADDR_W-1:0] addr_q, shift_q;
  logic [SCNT_W:0] rem_q, rem_sh;
  logic [STEP_W-1:0] step_q;
  logic [SET_W-1:0] set_q;

  assign rem_sh = {rem_q[SCNT_W-1:0], shift_q[ADDR_W-1]};
  assign stat.mod_done = (step_q == STEP_W'(ADDR_W));

  always_ff @(posedge clk) begin
    if (ctrl.start_mod) begin
      addr_q <= address;
      shift_q <= address;
      rem_q <= '0;
      step_q <= '0;
    end else if (ctrl.step_mod && !stat.mod_done) begin
      shift_q <= {shift_q[ADDR_W-2:0], 1'b0};
      rem_q <= (rem_sh >= {1'b0, sets_eff}) ? rem_sh - {1'b0, sets_eff} : rem_sh;
      step_q <= step_q + STEP_W'(1);
    end
    if (ctrl.read_set) begin
      set_q <= rem_q[SET_W-1:0];
    end
  end

  // Clearing pass over the rank and valid memories after reset.
  logic [SET_W:0] clr_q;
  logic clearing;
  assign clearing = (clr_q != (SET_W+1)'(MAX_SETS));
  assign stat.clear_done = (clr_q == (SET_W+1)'(MAX_SETS - 1)) || !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + (SET_W+1)'(1);
    end
  end

  logic [MAX_WAYS*ADDR_W-1:0] tag_rd, tag_wr;
  logic [MAX_WAYS*RANK_W-1:0] rank_rd, rank_wr;
  logic [MAX_WAYS-1:0] valid_rd, valid_wr;
  logic [SET_W-1:0] mem_addr;
  logic tag_we;

  assign mem_addr = clearing ? clr_q[SET_W-1:0] : (ctrl.read_set ? rem_q[SET_W-1:0] : set_q);
  assign tag_we = ctrl.write_back && !clearing;

  sacl_ram #(.WIDTH(MAX_WAYS*ADDR_W), .DEPTH(MAX_SETS)) u_tags (
    .clk(clk), .we(tag_we), .addr(mem_addr), .wdata(tag_wr), .rdata(tag_rd)
  );

  sacl_ram #(.WIDTH(MAX_WAYS*RANK_W), .DEPTH(MAX_SETS)) u_ranks (
    .clk(clk), .we(ctrl.write_back), .addr(mem_addr),
    .wdata(clearing ? '0 : rank_wr), .rdata(rank_rd)
  );

  sacl_ram #(.WIDTH(MAX_WAYS), .DEPTH(MAX_SETS)) u_valid (
    .clk(clk), .we(ctrl.write_back), .addr(mem_addr),
    .wdata(clearing ? '0 : valid_wr), .rdata(valid_rd)
  );

  // Decision stage: search the set read in the previous cycle.
  logic [MAX_WAYS-1:0] vrow, act;
  logic d_hit, d_found;
  logic [WAY_W-1:0] d_way;
  logic [RANK_W-1:0] d_limit;
  logic d_full_age;

  assign vrow = valid_rd;

  always_comb begin
    logic [RANK_W-1:0] best;
    logic got;
    d_hit = 1'b0;
    d_found = 1'b0;
    d_way = '0;
    best = '0;
    got = 1'b0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      act[k] = (WCNT_W'(k) < ways_eff);
    end
    for (int k = MAX_WAYS-1; k >= 0; k--) begin
      if (act[k] && vrow[k] && tag_rd[k*ADDR_W +: ADDR_W] == addr_q) begin
        d_hit = 1'b1;
        d_way = WAY_W'(k);
      end
    end
    if (!d_hit) begin
      for (int k = MAX_WAYS-1; k >= 0; k--) begin
        if (act[k] && !vrow[k]) begin
          d_found = 1'b1;
          d_way = WAY_W'(k);
        end
      end
      if (!d_found) begin
        for (int k = 0; k < MAX_WAYS; k++) begin
          if (act[k] && (!got || rank_rd[k*RANK_W +: RANK_W] > best)) begin
            best = rank_rd[k*RANK_W +: RANK_W];
            d_way = WAY_W'(k);
            got = 1'b1;
          end
        end
      end
    end
    d_limit = rank_rd[d_way*RANK_W +: RANK_W];
    d_full_age = !d_hit && d_found;
  end

  logic r_hit, r_ev, r_full;
  logic [WAY_W-1:0] r_way;
  logic [RANK_W-1:0] r_limit;
  logic [MAX_WAYS*RANK_W-1:0] r_rank;
  logic [MAX_WAYS*ADDR_W-1:0] r_tag;
  logic [MAX_WAYS-1:0] r_valid;
  logic [CNT_W-1:0] hits, misses;

  always_ff @(posedge clk) begin
    if (ctrl.decide) begin
      r_hit <= d_hit;
      r_ev <= !d_hit && !d_found;
      r_full <= d_full_age;
      r_way <= d_way;
      r_limit <= d_limit;
      r_rank <= rank_rd;
      r_tag <= tag_rd;
      r_valid <= vrow;
    end
  end

  always_comb begin
    tag_wr = r_tag;
    rank_wr = r_rank;
    valid_wr = r_valid;
    valid_wr[r_way] = 1'b1;
    if (!r_hit) begin
      tag_wr[r_way*ADDR_W +: ADDR_W] = addr_q;
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) == r_way) begin
        rank_wr[k*RANK_W +: RANK_W] = '0;
      end else if (act[k] && r_valid[k] &&
                   (r_full || r_rank[k*RANK_W +: RANK_W] < r_limit) &&
                   r_rank[k*RANK_W +: RANK_W] < RANK_MAX) begin
        rank_wr[k*RANK_W +: RANK_W] = r_rank[k*RANK_W +: RANK_W] + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '0;
      misses <= '0;
    end else if (ctrl.load_out) begin
      if (r_hit && hits != '1) begin
        hits <= hits + CNT_W'(1);
      end
      if (!r_hit && misses != '1) begin
        misses <= misses + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      hit <= r_hit;
      set_index <= SET_OUT_W'(set_q);
      way_index <= WAY_OUT_W'(r_way);
      evicted <= r_ev;
    end
  end

  assign hit_total = hits;
  assign miss_total = misses;

endmodule

// ===== hw/rtl/set_assoc_cache_lru_top.sv =====
// Set-associative cache with LRU replacement: one address per request,
// one result per request. The set index is computed by a serial restoring
// modulo at one address bit per cycle, followed by the memory read, decision
// and write back; the next request is accepted once the result is taken.
// After reset a clearing pass zeroes the rank and valid memories before the
// first request is accepted.
// Top level; depends on sacl_pkg, sacl_ctrl, sacl_dp and sacl_ram.
module set_assoc_cache_lru_top #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sacl_pkg::ADDR_W-1:0]     address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [sacl_pkg::SET_OUT_W-1:0]  set_index,
  output logic [sacl_pkg::WAY_OUT_W-1:0]  way_index,
  output logic                           evicted,
  output logic [sacl_pkg::CNT_W-1:0]      hit_total,
  output logic [sacl_pkg::CNT_W-1:0]      miss_total
);
  import sacl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sacl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .ctrl(ctrl), .stat(stat)
  );

  sacl_dp #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .address(address), .ctrl(ctrl), .stat(stat),
    .hit(hit), .set_index(set_index), .way_index(way_index), .evicted(evicted),
    .hit_total(hit_total), .miss_total(miss_total)
  );

endmodule

// ===== bench/set_assoc_cache_lru_top_tb.sv =====
// Self-checking bench for the set-associative LRU cache top level.
// Predicts hit, set, way, eviction and counters per request and compares
// every result; depends on sacl_pkg and set_assoc_cache_lru_top.
module set_assoc_cache_lru_top_tb;
  import sacl_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 64;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic        hit;
    logic [5:0]  set_index;
    logic [2:0]  way_index;
    logic        evicted;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [SET_OUT_W-1:0] set_index;
  logic [WAY_OUT_W-1:0] way_index;
  logic evicted;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;

  set_assoc_cache_lru_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0] mdl_tag [NSETS*NWAYS];
  logic        mdl_valid [NSETS*NWAYS];
  logic [2:0]  mdl_rank [NSETS*NWAYS];
  logic [31:0] mdl_hits, mdl_misses;
  logic [3:0]  mdl_ways_reg;
  logic [6:0]  mdl_sets_reg;
  lookup_t     pending_lookups[$];
  int errors = 0;
  int requests = 0;
  int results = 0;
  int idle_cycles = 0;
  bit stall_out = 1'b0;

  task automatic reset_model();
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      mdl_tag[i] = '0;
      mdl_valid[i] = 1'b0;
      mdl_rank[i] = '0;
    end
    mdl_hits = '0;
    mdl_misses = '0;
    mdl_ways_reg = 4'd8;
    mdl_sets_reg = 7'd64;
  endtask

  task automatic age_set(int base, int ways, int w, int lim);
    for (int k = 0; k < ways; k++)
      if (k != w && mdl_valid[base+k] && mdl_rank[base+k] < lim && mdl_rank[base+k] < NWAYS-1)
        mdl_rank[base+k]++;
    mdl_rank[base+w] = '0;
  endtask

  function automatic int used_ways();
    if (mdl_ways_reg == 0) return 1;
    if (mdl_ways_reg > NWAYS) return NWAYS;
    return mdl_ways_reg;
  endfunction

  function automatic int used_sets();
    if (mdl_sets_reg == 0) return 1;
    if (mdl_sets_reg > NSETS) return NSETS;
    return mdl_sets_reg;
  endfunction

  task automatic predict_lookup(logic [31:0] addr);
    lookup_t r;
    int ways, sidx, base, w, best;
    bit found;
    ways = used_ways();
    sidx = addr % used_sets();
    base = sidx * NWAYS;
    w = 0;
    found = 1'b0;
    r = '0;
    for (int k = 0; k < ways; k++)
      if (!found && mdl_valid[base+k] && mdl_tag[base+k] == addr) begin
        found = 1'b1;
        w = k;
      end
    if (found) begin
      r.hit = 1'b1;
      age_set(base, ways, w, mdl_rank[base+w]);
      if (mdl_hits != 32'hFFFF_FFFF) mdl_hits++;
    end else begin
      for (int k = 0; k < ways; k++)
        if (!found && !mdl_valid[base+k]) begin
          found = 1'b1;
          w = k;
        end
      if (found) begin
        mdl_valid[base+w] = 1'b1;
        mdl_tag[base+w] = addr;
        age_set(base, ways, w, 1000);
      end else begin
        best = 0;
        w = 0;
        for (int k = 0; k < ways; k++)
          if (k == 0 || mdl_rank[base+k] > best) begin
            best = mdl_rank[base+k];
            w = k;
          end
        r.evicted = 1'b1;
        mdl_tag[base+w] = addr;
        age_set(base, ways, w, best);
      end
      if (mdl_misses != 32'hFFFF_FFFF) mdl_misses++;
    end
    r.set_index = sidx[5:0];
    r.way_index = w[2:0];
    r.hit_total = mdl_hits;
    r.miss_total = mdl_misses;
    pending_lookups.insert(pending_lookups.size(), r);
  endtask

  task automatic send_lookup(logic [31:0] addr);
    int gap;
    gap = $urandom_range(0, 16) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address <= addr;
    do @(posedge clk); while (!in_ready);
    predict_lookup(addr);
    requests++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ACTIVE_WAYS) mdl_ways_reg = val[3:0];
    else mdl_sets_reg = val;
    @(posedge clk);
  endtask

  task automatic set_geometry(int ways, int sets);
    wait_drained();
    write_reg(REG_ACTIVE_WAYS, ways[6:0]);
    write_reg(REG_NUM_SETS, sets[6:0]);
  endtask

  // Random stream with a small working set so that hits and evictions both occur.
  task automatic run_random(int n, int span);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom();
      end else begin
        a = $urandom_range(0, span);
        if ($urandom_range(0, 1) != 0) a[31] = ~a[31];
      end
      send_lookup(a);
    end
  endtask

  task automatic test_directed_extremes();
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hAAAA_AAAA);
    send_lookup(32'h5555_5555);
  endtask

  task automatic test_lru_eviction();
    set_geometry(2, 1);
    send_lookup(32'd10);
    send_lookup(32'd11);
    send_lookup(32'd10);
    send_lookup(32'd12);
    send_lookup(32'd11);
    send_lookup(32'd10);
    send_lookup(32'd12);
  endtask

  task automatic test_out_of_range_config();
    set_geometry(0, 0);
    send_lookup(32'd3);
    send_lookup(32'd4);
    send_lookup(32'd3);
    set_geometry(15, 127);
    send_lookup(32'd127);
    send_lookup(32'd191);
    set_geometry(4, 3);
    send_lookup(32'd3);
    send_lookup(32'd4);
  endtask

  task automatic test_random_geometries();
    set_geometry(8, 64);
    run_random(300, 2000);
    set_geometry(1, 1);
    run_random(150, 8);
    set_geometry(3, 5);
    run_random(250, 60);
    set_geometry($urandom_range(1, 8), $urandom_range(1, 64));
    run_random(250, 300);
    set_geometry(8, 1);
    run_random(300, 14);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results++;
        if (pending_lookups.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          lookup_t e;
          e = pending_lookups.pop_front();
          if (hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, hit); errors++;
          end
          if (set_index !== e.set_index) begin
            $error("set_index exp %0d got %0d", e.set_index, set_index); errors++;
          end
          if (way_index !== e.way_index) begin
            $error("way_index exp %0d got %0d", e.way_index, way_index); errors++;
          end
          if (evicted !== e.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, evicted); errors++;
          end
          if (hit_total !== e.hit_total) begin
            $error("hit_total exp %0d got %0d", e.hit_total, hit_total); errors++;
          end
          if (miss_total !== e.miss_total) begin
            $error("miss_total exp %0d got %0d", e.miss_total, miss_total); errors++;
          end
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if (!stall_out && gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_lru_eviction();
    test_out_of_range_config();
    test_random_geometries();
    wait_drained();
    $display("Sent %0d lookups and checked %0d results over several way and set counts.",
             requests, results);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_ctrl.sv
hw/rtl/sacl_dp.sv
hw/rtl/set_assoc_cache_lru_top.sv
bench/set_assoc_cache_lru_top_tb.sv
